// ===== design/psc_pkg.sv =====
// shared types and constants for the palindromic subsequence counter
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

  localparam int unsigned CNT_W = 64;

  // per interval: total count, count with last byte kept, count with first byte kept
  typedef struct packed {
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } cell_t;

  localparam int unsigned CELL_W = $bits(cell_t);

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

endpackage
`default_nettype wire

// ===== design/psc_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module psc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/palindromic_subsequence_counter_unit.sv =====
// palindromic subsequence counter: byte store, interval sequencer and shared adder
// loading: n bytes cost n load transfers, then the interval pass runs to the result
// throughput: one byte per cycle while loading; not ready during the interval pass
// the interval pass is set by one shared 64-bit adder, five adds and two reads per interval
// reset: rst_ni low clears control, length and flag asynchronously; rams are not cleared
// the result register holds one finished count so loading of the next string continues
`timescale 1ns / 1ps
`default_nettype none
module palindromic_subsequence_counter_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                char_in_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [psc_pkg::CNT_W-1:0] count_o,
  output logic                      too_long_o
);

  import psc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN > 1 ? MAX_LEN : 2);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_RD0,
    ST_RD1,
    ST_ADD_K,
    ST_ADD_A,
    ST_ADD_B,
    ST_ADD_T,
    ST_ADD_S,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] n_q, n_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] span_q, span_d;
  logic          drop_q, drop_d;
  logic [1:0]    bw_q, bw_d, b1_q, b1_d, b2_q, b2_d;
  logic          out_valid_q, out_valid_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic          too_long_q, too_long_d;

  logic             eq_q;
  logic [CNT_W-1:0] sin_q, ar_q, bl_q, k11_q, an_q, bn_q, t_q, res_q;

  logic             in_xfer;
  logic [LW-1:0]    idx_p1;
  logic [LW:0]      j_full;
  logic [LW:0]      end_full;
  logic             last_start;
  logic [7:0]       ch_a, ch_b;
  logic [AW-1:0]    rd_addr;
  cell_t            rdata [3];
  cell_t            bank1, bank2;
  cell_t            wcell;
  logic             bank_we;
  logic [CNT_W-1:0] add_a, add_b, add_sum;
  logic [CNT_W-1:0] sin_rd;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign idx_p1     = idx_q + LW'(1);
  assign j_full     = {1'b0, idx_q} + {1'b0, span_q} - (LW + 1)'(1);
  assign end_full   = {1'b0, idx_q} + {1'b0, span_q};
  assign last_start = (end_full == {1'b0, n_q});

  // byte store, duplicated for two read addresses
  psc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_a (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (len_q < LW'(MAX_LEN))),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (char_in_i),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ch_a)
  );

  psc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_b (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (len_q < LW'(MAX_LEN))),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (char_in_i),
    .raddr_i (j_full[AW-1:0]),
    .rdata_o (ch_b)
  );

  // three rotating banks hold lengths span, span-1 and span-2, indexed by start
  assign rd_addr = (state_q == ST_RD1) ? idx_p1[AW-1:0] : idx_q[AW-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_bank
    psc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_LEN)) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we && (bw_q == 2'(k))),
      .waddr_i (idx_q[AW-1:0]),
      .wdata_i (wcell),
      .raddr_i (rd_addr),
      .rdata_o (rdata[k])
    );
  end

  always_comb begin
    case (b1_q)
      2'd1:    bank1 = rdata[1];
      2'd2:    bank1 = rdata[2];
      default: bank1 = rdata[0];
    endcase
    case (b2_q)
      2'd1:    bank2 = rdata[1];
      2'd2:    bank2 = rdata[2];
      default: bank2 = rdata[0];
    endcase
  end

  assign sin_rd = (span_q == LW'(2)) ? '0 : bank2.s;

  // shared adder
  always_comb begin
    case (state_q)
      ST_ADD_K: begin
        add_a = sin_rd;
        add_b = CNT_ONE;
      end
      ST_ADD_A: begin
        add_a = ar_q;
        add_b = k11_q;
      end
      ST_ADD_B: begin
        add_a = bl_q;
        add_b = k11_q;
      end
      ST_ADD_T: begin
        add_a = sin_q;
        add_b = an_q;
      end
      default: begin
        add_a = t_q;
        add_b = bl_q;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  always_comb begin
    bank_we = 1'b0;
    wcell   = '{s: add_sum, a: an_q, b: bn_q};
    if (state_q == ST_BASE) begin
      bank_we = 1'b1;
      wcell   = '{s: CNT_ONE, a: CNT_ONE, b: CNT_ONE};
    end else if (state_q == ST_ADD_S) begin
      bank_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    n_d         = n_q;
    idx_d       = idx_q;
    span_d      = span_q;
    drop_d      = drop_q;
    bw_d        = bw_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    out_valid_d = out_valid_q && !out_ready_i;
    count_d     = count_q;
    too_long_d  = too_long_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (len_q < LW'(MAX_LEN)) begin
            len_d = len_q + LW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            n_d     = (len_q < LW'(MAX_LEN)) ? len_q + LW'(1) : len_q;
            idx_d   = '0;
            span_d  = LW'(1);
            bw_d    = 2'd0;
            b1_d    = 2'd2;
            b2_d    = 2'd1;
            state_d = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        if (idx_p1 == n_q) begin
          if (n_q == LW'(1)) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = '0;
            span_d  = LW'(2);
            bw_d    = b2_q;
            b1_d    = bw_q;
            b2_d    = b1_q;
            state_d = ST_RD0;
          end
        end else begin
          idx_d = idx_p1;
        end
      end
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_ADD_K;
      ST_ADD_K: state_d = ST_ADD_A;
      ST_ADD_A: state_d = ST_ADD_B;
      ST_ADD_B: state_d = ST_ADD_T;
      ST_ADD_T: state_d = ST_ADD_S;
      ST_ADD_S: begin
        if (last_start) begin
          if (span_q == n_q) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = '0;
            span_d  = span_q + LW'(1);
            bw_d    = b2_q;
            b1_d    = bw_q;
            b2_d    = b1_q;
            state_d = ST_RD0;
          end
        end else begin
          idx_d   = idx_p1;
          state_d = ST_RD0;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          count_d     = res_q;
          too_long_d  = drop_q;
          len_d       = '0;
          drop_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      span_q      <= '0;
      drop_q      <= 1'b0;
      bw_q        <= 2'd0;
      b1_q        <= 2'd2;
      b2_q        <= 2'd1;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      too_long_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      span_q      <= span_d;
      drop_q      <= drop_d;
      bw_q        <= bw_d;
      b1_q        <= b1_d;
      b2_q        <= b2_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      too_long_q  <= too_long_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD1) begin
      eq_q <= (ch_a == ch_b);
      bl_q <= bank1.b;
    end
    if (state_q == ST_ADD_K) begin
      sin_q <= sin_rd;
      ar_q  <= bank1.a;
      k11_q <= eq_q ? add_sum : '0;
    end
    if (state_q == ST_ADD_A) begin
      an_q <= add_sum;
    end
    if (state_q == ST_ADD_B) begin
      bn_q <= add_sum;
    end
    if (state_q == ST_ADD_T) begin
      t_q <= add_sum;
    end
    if (bank_we && (idx_q == '0)) begin
      res_q <= wcell.s;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign too_long_o  = too_long_q;

`ifndef ASSERT_OFF
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_LEN))
    else $error("stored length beyond maximum");

  a_span_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD0) |-> (end_full <= {1'b0, n_q}) && (span_q >= LW'(2)))
    else $error("interval reaches past stored bytes");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("ready right after last byte transfer");

  a_banks_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bw_q != b1_q) && (bw_q != b2_q) && (b1_q != b2_q))
    else $error("bank roles overlap");
`endif

endmodule
`default_nettype wire

// ===== test/tb_palindromic_subsequence_counter_unit.sv =====
// testbench for the palindromic subsequence counter: directed and random strings checked against a scoreboard
`timescale 1ns / 1ps
module tb_palindromic_subsequence_counter_unit;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned ITEM_TARGET = 1000;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned LONG_RANDOM_MAX = 4;

  typedef enum int {ANY_BYTE, TWO_SYMBOLS, FOUR_SYMBOLS} byte_style_e;

  class count_scoreboard;
    bit [7:0] held[MAX_LEN];
    int unsigned held_len;
    bit dropped;
    bit [63:0] keep_none[MAX_LEN][MAX_LEN];
    bit [63:0] keep_first[MAX_LEN][MAX_LEN];
    bit [63:0] keep_last[MAX_LEN][MAX_LEN];
    bit [63:0] keep_both[MAX_LEN][MAX_LEN];
    bit [63:0] expected_counts[$];
    bit expected_flags[$];
    int unsigned errors;

    function bit [63:0] cell_total(int unsigned i, int unsigned j);
      return keep_none[i][j] + keep_last[i][j] + keep_first[i][j] + keep_both[i][j];
    endfunction

    function bit [63:0] palindrome_total(int unsigned n);
      int unsigned i;
      int unsigned j;
      int unsigned span;
      bit [63:0] inner;
      if (n == 0) return '0;
      for (i = 0; i < n; i++) begin
        keep_none[i][i] = 0;
        keep_last[i][i] = 0;
        keep_first[i][i] = 0;
        keep_both[i][i] = 1;
        if (i + 1 < n) begin
          keep_none[i][i+1] = 0;
          keep_last[i][i+1] = 1;
          keep_first[i][i+1] = 1;
          keep_both[i][i+1] = (held[i] == held[i+1]) ? 64'd1 : 64'd0;
        end
      end
      for (span = 3; span <= n; span++) begin
        for (i = 0; i + span <= n; i++) begin
          j = i + span - 1;
          inner = cell_total(i + 1, j - 1);
          keep_none[i][j] = inner;
          keep_last[i][j] = keep_last[i+1][j] + keep_both[i+1][j];
          keep_first[i][j] = keep_first[i][j-1] + keep_both[i][j-1];
          keep_both[i][j] = (held[i] == held[j]) ? inner + 64'd1 : 64'd0;
        end
      end
      return cell_total(0, n - 1);
    endfunction

    function void note_byte(bit [7:0] c, bit is_last);
      if (held_len < MAX_LEN) begin
        held[held_len] = c;
        held_len++;
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        expected_counts.push_back(palindrome_total(held_len));
        expected_flags.push_back(dropped);
        held_len = 0;
        dropped = 1'b0;
      end
    endfunction

    function void check_result(bit [63:0] got_count, bit got_flag);
      bit [63:0] want_count;
      bit want_flag;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got count %0d too_long %0b",
                 $time, got_count, got_flag);
        errors++;
        return;
      end
      want_count = expected_counts.pop_front();
      want_flag = expected_flags.pop_front();
      if (got_count !== want_count) begin
        $display("%0t: count mismatch, expected %0d, got %0d", $time, want_count, got_count);
        errors++;
      end
      if (got_flag !== want_flag) begin
        $display("%0t: too_long mismatch, expected %0b, got %0b", $time, want_flag, got_flag);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] char_in_i;
  logic last_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [psc_pkg::CNT_W-1:0] count_o;
  logic too_long_o;

  count_scoreboard sb;
  bit [7:0] text_q[$];
  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned cycles;
  bit send_idle;
  bit recv_idle;
  bit hold_req;

  palindromic_subsequence_counter_unit #(.MAX_LEN(MAX_LEN)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_in_i  (char_in_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .count_o    (count_o),
    .too_long_o (too_long_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bit [7:0] pick_byte(byte_style_e style, bit [7:0] base);
    case (style)
      TWO_SYMBOLS:  return base ^ 8'($urandom_range(0, 1));
      FOUR_SYMBOLS: return base + 8'($urandom_range(0, 3));
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // valid stays high across back-to-back strings; callers park the sender when done
  task automatic send_text();
    int gap;
    bit is_last;
    for (int k = 0; k < text_q.size(); k++) begin
      gap = send_idle ? $urandom_range(0, 4) : 0;
      is_last = (k == text_q.size() - 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      char_in_i <= text_q[k];
      last_i <= is_last;
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_byte(text_q[k], is_last);
      items_sent++;
    end
  endtask

  task automatic send_short(input bit [7:0] b0, input bit [7:0] b1, input bit [7:0] b2,
                            input bit [7:0] b3, input bit [7:0] b4, input int len);
    bit [7:0] pool[5];
    pool = '{b0, b1, b2, b3, b4};
    text_q.delete();
    for (int k = 0; k < len; k++) text_q.push_back(pool[k]);
    send_text();
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // result side
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(count_o, too_long_o);
      if ($urandom_range(0, 19) == 0) recv_idle = !recv_idle;
    end
  end

  initial begin
    byte_style_e style;
    bit [7:0] base;
    int len;
    int long_left;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    char_in_i = '0;
    last_i = 1'b0;
    out_ready_i = 1'b0;
    items_sent = 0;
    strings_sent = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req = 1'b0;
    long_left = LONG_RANDOM_MAX;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single bytes, pairs, odd and even palindromes
    send_short(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1);
    send_short(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1);
    send_short(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2);
    send_short(8'hA5, 8'h5A, 8'h00, 8'h00, 8'h00, 2);
    send_short(8'h61, 8'h62, 8'h61, 8'h00, 8'h00, 3);
    send_short(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 4);
    send_short(8'h01, 8'h02, 8'h03, 8'h02, 8'h01, 5);
    send_short(8'h80, 8'h7F, 8'h80, 8'h7F, 8'h00, 4);
    pause_until_drained();

    // full store of one symbol gives the largest count
    text_q.delete();
    repeat (MAX_LEN) text_q.push_back(8'h55);
    send_text();
    // dropped byte carries the last mark
    text_q.delete();
    repeat (MAX_LEN + 1) text_q.push_back(pick_byte(TWO_SYMBOLS, 8'h3C));
    send_text();
    // several bytes dropped
    text_q.delete();
    repeat (MAX_LEN + 6) text_q.push_back(pick_byte(ANY_BYTE, 8'h00));
    send_text();
    pause_until_drained();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) send_idle = !send_idle;
      style = byte_style_e'($urandom_range(0, 2));
      base = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 3 && long_left > 0) begin
        len = $urandom_range(MAX_LEN - 4, MAX_LEN + 8);
        long_left--;
      end else begin
        len = $urandom_range(1, 14);
      end
      text_q.delete();
      repeat (len) text_q.push_back(pick_byte(style, base));
      send_text();
      strings_sent++;
      if (strings_sent == 15) hold_req = 1'b1;
      if (strings_sent == 40) pause_until_drained();
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
